/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the steering RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pdst_pkg.sv */
// ----------------------------------------------------------------------------
// pdst_pkg
// Types and constants for the PD steering block with turn commitment.
// ----------------------------------------------------------------------------
package pdst_pkg;

  localparam int BEARING_W  = 8;
  localparam int AREA_W     = 20;
  localparam int TIME_W     = 32;
  localparam int SPEED_W    = 11;
  localparam int DZ_W       = 7;
  localparam int WIN_W      = 16;
  localparam int TURN_W     = 10;
  localparam int DRIVE_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 24;

  // Derivative gain 12/10 as a fixed-point reciprocal, 2^16 scale.
  // Exact truncation for |delta bearing| up to 255.
  localparam int KD_RECIP_W = 17;
  localparam logic [KD_RECIP_W-1:0] KD_RECIP = 17'd78648;
  localparam int KD_SHIFT   = 16;

  localparam logic signed [TURN_W:0]  TURN_HI  = 11'sd511;
  localparam logic signed [TURN_W:0]  TURN_LO  = -11'sd512;
  localparam logic signed [DRIVE_W:0] DRIVE_HI = 12'sd1000;
  localparam logic signed [DRIVE_W:0] DRIVE_LO = -12'sd1000;

  localparam logic signed [SPEED_W-1:0] RST_BASE_NEAR    = 11'sd300;
  localparam logic signed [SPEED_W-1:0] RST_BASE_MID     = 11'sd500;
  localparam logic signed [SPEED_W-1:0] RST_BASE_FAR     = 11'sd800;
  localparam logic [AREA_W-1:0]         RST_NEAR_AREA    = 20'd15000;
  localparam logic [AREA_W-1:0]         RST_FAR_AREA     = 20'd3000;
  localparam logic [DZ_W-1:0]           RST_DEADZONE     = 7'd8;
  localparam logic [WIN_W-1:0]          RST_COMMIT_WIN   = 16'd150;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_NEAR     = 3'd0,
    REG_BASE_MID      = 3'd1,
    REG_BASE_FAR      = 3'd2,
    REG_NEAR_AREA     = 3'd3,
    REG_FAR_AREA      = 3'd4,
    REG_DEADZONE      = 3'd5,
    REG_COMMIT_WINDOW = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] base_near;
    logic signed [SPEED_W-1:0] base_mid;
    logic signed [SPEED_W-1:0] base_far;
    logic [AREA_W-1:0]         near_area;
    logic [AREA_W-1:0]         far_area;
    logic [DZ_W-1:0]           deadzone;
    logic [WIN_W-1:0]          commit_window;
  } cfg_t;

  typedef struct packed {
    logic signed [BEARING_W-1:0] bearing;
    logic [AREA_W-1:0]           target_area;
    logic [TIME_W-1:0]           time_ms;
  } sample_t;

  typedef struct packed {
    logic signed [BEARING_W-1:0] last_bearing;
    logic signed [TURN_W-1:0]    held_turn;
    logic [TIME_W-1:0]           hold_start_time;
  } steer_state_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
  } drive_t;

endpackage

/* design/pdst_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pdst_cfg_regs
// Configuration register file, write-only, indexed by register number.
// ----------------------------------------------------------------------------
module pdst_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [pdst_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [pdst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pdst_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_near     <= pdst_pkg::RST_BASE_NEAR;
      cfg.base_mid      <= pdst_pkg::RST_BASE_MID;
      cfg.base_far      <= pdst_pkg::RST_BASE_FAR;
      cfg.near_area     <= pdst_pkg::RST_NEAR_AREA;
      cfg.far_area      <= pdst_pkg::RST_FAR_AREA;
      cfg.deadzone      <= pdst_pkg::RST_DEADZONE;
      cfg.commit_window <= pdst_pkg::RST_COMMIT_WIN;
    end else if (cfg_wen) begin
      case (pdst_pkg::cfg_reg_t'(cfg_addr))
        pdst_pkg::REG_BASE_NEAR: begin
          cfg.base_near <= $signed(cfg_wdata[pdst_pkg::SPEED_W-1:0]);
        end
        pdst_pkg::REG_BASE_MID: begin
          cfg.base_mid <= $signed(cfg_wdata[pdst_pkg::SPEED_W-1:0]);
        end
        pdst_pkg::REG_BASE_FAR: begin
          cfg.base_far <= $signed(cfg_wdata[pdst_pkg::SPEED_W-1:0]);
        end
        pdst_pkg::REG_NEAR_AREA: begin
          cfg.near_area <= cfg_wdata[pdst_pkg::AREA_W-1:0];
        end
        pdst_pkg::REG_FAR_AREA: begin
          cfg.far_area <= cfg_wdata[pdst_pkg::AREA_W-1:0];
        end
        pdst_pkg::REG_DEADZONE: begin
          cfg.deadzone <= cfg_wdata[pdst_pkg::DZ_W-1:0];
        end
        pdst_pkg::REG_COMMIT_WINDOW: begin
          cfg.commit_window <= cfg_wdata[pdst_pkg::WIN_W-1:0];
        end
        default: begin
          // unused index: ignored
        end
      endcase
    end
  end

endmodule

/* design/pdst_steer_law.sv */
// ----------------------------------------------------------------------------
// pdst_steer_law
// Combinational steering law: base speed, PD turn, commitment, saturation.
// ----------------------------------------------------------------------------
module pdst_steer_law (
  input  pdst_pkg::sample_t       smp,
  input  pdst_pkg::steer_state_t  st,
  input  pdst_pkg::cfg_t          cfg,
  output pdst_pkg::steer_state_t  st_next,
  output pdst_pkg::drive_t        drive
);

  logic [pdst_pkg::BEARING_W-1:0]              d_mag;
  logic                                        centred;
  logic [pdst_pkg::TIME_W-1:0]                 elapsed;
  logic                                        live;
  logic signed [pdst_pkg::SPEED_W-1:0]         base;
  logic signed [pdst_pkg::BEARING_W:0]         diff;
  logic [pdst_pkg::BEARING_W-1:0]              diff_mag;
  logic [pdst_pkg::BEARING_W+pdst_pkg::KD_RECIP_W-1:0] q_prod;
  logic [pdst_pkg::BEARING_W+pdst_pkg::KD_RECIP_W-pdst_pkg::KD_SHIFT-1:0] q_mag;
  logic signed [pdst_pkg::TURN_W:0]            q_term;
  logic signed [pdst_pkg::TURN_W:0]            p_term;
  logic signed [pdst_pkg::TURN_W:0]            pd_raw;
  logic signed [pdst_pkg::TURN_W-1:0]          pd_turn;
  logic                                        flip_blocked;
  logic signed [pdst_pkg::TURN_W-1:0]          turn;
  logic signed [pdst_pkg::DRIVE_W:0]           left_sum;
  logic signed [pdst_pkg::DRIVE_W:0]           right_sum;

  function automatic logic signed [pdst_pkg::DRIVE_W-1:0] sat_drive(
    input logic signed [pdst_pkg::DRIVE_W:0] v
  );
    logic signed [pdst_pkg::DRIVE_W:0] r;
    r = v;
    if (v > pdst_pkg::DRIVE_HI) r = pdst_pkg::DRIVE_HI;
    if (v < pdst_pkg::DRIVE_LO) r = pdst_pkg::DRIVE_LO;
    return r[pdst_pkg::DRIVE_W-1:0];
  endfunction

  always_comb begin
    // |bearing|; -128 maps to 128, which still fits unsigned
    d_mag   = smp.bearing[pdst_pkg::BEARING_W-1] ?
              (pdst_pkg::BEARING_W)'(-smp.bearing) : smp.bearing;
    centred = d_mag < {1'b0, cfg.deadzone};

    elapsed = smp.time_ms - st.hold_start_time;
    live    = elapsed < {{(pdst_pkg::TIME_W-pdst_pkg::WIN_W){1'b0}}, cfg.commit_window};

    if (smp.target_area > cfg.near_area) begin
      base = cfg.base_near;
    end else if (smp.target_area < cfg.far_area) begin
      base = cfg.base_far;
    end else begin
      base = cfg.base_mid;
    end

    // D term: trunc(1.2 * delta) via magnitude and reciprocal multiply
    diff     = {smp.bearing[pdst_pkg::BEARING_W-1], smp.bearing}
             - {st.last_bearing[pdst_pkg::BEARING_W-1], st.last_bearing};
    diff_mag = diff[pdst_pkg::BEARING_W] ?
               (pdst_pkg::BEARING_W)'(-diff) : diff[pdst_pkg::BEARING_W-1:0];
    q_prod   = (pdst_pkg::BEARING_W+pdst_pkg::KD_RECIP_W)'(diff_mag)
             * (pdst_pkg::BEARING_W+pdst_pkg::KD_RECIP_W)'(pdst_pkg::KD_RECIP);
    q_mag    = q_prod[pdst_pkg::BEARING_W+pdst_pkg::KD_RECIP_W-1:pdst_pkg::KD_SHIFT];
    q_term   = diff[pdst_pkg::BEARING_W] ?
               -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});

    // P term: 20/10 is exactly 2
    p_term   = {{2{smp.bearing[pdst_pkg::BEARING_W-1]}}, smp.bearing, 1'b0};
    pd_raw   = p_term + q_term;
    if (pd_raw > pdst_pkg::TURN_HI) begin
      pd_turn = pdst_pkg::TURN_HI[pdst_pkg::TURN_W-1:0];
    end else if (pd_raw < pdst_pkg::TURN_LO) begin
      pd_turn = pdst_pkg::TURN_LO[pdst_pkg::TURN_W-1:0];
    end else begin
      pd_turn = pd_raw[pdst_pkg::TURN_W-1:0];
    end

    flip_blocked = ((pd_turn > 0) != (st.held_turn > 0))
                 && (st.held_turn != '0) && live;

    st_next              = st;
    st_next.last_bearing = smp.bearing;
    if (centred) begin
      turn = live ? st.held_turn : '0;
    end else if (flip_blocked) begin
      turn = st.held_turn;
    end else begin
      turn                    = pd_turn;
      st_next.held_turn       = pd_turn;
      st_next.hold_start_time = smp.time_ms;
    end

    left_sum  = {base[pdst_pkg::SPEED_W-1], base}
              + {{2{turn[pdst_pkg::TURN_W-1]}}, turn};
    right_sum = {base[pdst_pkg::SPEED_W-1], base}
              - {{2{turn[pdst_pkg::TURN_W-1]}}, turn};
    drive.left_drive  = sat_drive(left_sum);
    drive.right_drive = sat_drive(right_sum);
  end

endmodule

/* design/pd_steering_with_turn_commit_top.sv */
// ----------------------------------------------------------------------------
// pd_steering_with_turn_commit_top
// Takes one sample beat per clock (bearing, area, timestamp) unless the
// output stalls, and returns one beat of left/right wheel commands per
// sample, in order. A beat is registered on input; once the output register
// is free or draining, the steering law result and the commitment state
// update are registered together into the output register and the state,
// and the commands are then presented with m_tvalid. One sample per cycle
// is sustained while m_tready is held high. The state loop (last bearing,
// held turn, hold start time) closes within the compute stage, so
// back-to-back samples need no gaps. Configuration writes take effect on the next clock and should be made while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pd_steering_with_turn_commit_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [pdst_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [pdst_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [7:0] bearing, [27:8] target_area, [59:28] time_ms, [63:60] zero
  input  logic [pdst_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [10:0] left_drive, [21:11] right_drive, [23:22] zero
  output logic [pdst_pkg::M_TDATA_W-1:0]    m_tdata
);

  pdst_pkg::cfg_t          cfg;
  pdst_pkg::sample_t       in_smp;
  logic                    in_valid;
  pdst_pkg::steer_state_t  st;
  pdst_pkg::steer_state_t  st_next;
  pdst_pkg::drive_t        drive_next;
  pdst_pkg::drive_t        drive;
  logic                    adv;

  pdst_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pdst_steer_law u_law (
    .smp     (in_smp),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .drive   (drive_next)
  );

  // compute stage moves when the output register is free or draining
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      st       <= '0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (adv) begin
        st       <= st_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_smp.bearing     <= $signed(s_tdata[7:0]);
      in_smp.target_area <= s_tdata[27:8];
      in_smp.time_ms     <= s_tdata[59:28];
    end
    if (adv) drive <= drive_next;
  end

  assign m_tdata = {2'b00, drive.right_drive, drive.left_drive};

  `ASSERT_NEXT(a_in_hold, clk, rst, in_valid && m_tvalid && !m_tready, in_valid && $stable(in_smp), "input beat lost under output stall")
  `ASSERT_NEXT(a_state_idle, clk, rst, !adv, $stable(st), "steering state moved without a beat")
  `ASSERT_NEXT(a_out_fill, clk, rst, adv, m_tvalid, "computed beat not presented")
  `ASSERT_IMPLIES(a_drive_range, clk, rst, m_tvalid, (drive.left_drive >= -11'sd1000) && (drive.left_drive <= 11'sd1000) && (drive.right_drive >= -11'sd1000) && (drive.right_drive <= 11'sd1000), "drive command outside limit")

endmodule
